[rtl/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// Length-prefix deframer package
// Shared types and constants for the 16-bit big-endian length deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

  // Header is two bytes, big-endian, and counts itself in the frame length
  localparam int unsigned HeaderLen = 2;
  localparam logic [15:0] MaxPayloadReset = 16'd16384;

  // Where the deframer is within a frame
  typedef enum logic [1:0] {
    PH_LEN_HI  = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // Status reported with each output word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_TOO_LONG  = 2'd2
  } frame_status_e;

  // One result from the frame tracker
  typedef struct packed {
    logic          valid;
    logic [7:0]    data;
    logic          last;
    frame_status_e status;
  } lpd_result_t;

endpackage

`default_nettype wire

[rtl/lpd_core.sv]
// ----------------------------------------------------------------------------
// Length-prefix deframer frame tracker
// Holds the header/payload state and turns one input byte into at most one
// result per step.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_core import lpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,       // consume byte_i this cycle
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] max_payload_i,
  output lpd_result_t      result_o
);

  localparam logic [15:0] HdrLen16 = 16'(HeaderLen);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] count_q, count_d;

  logic [15:0] hdr_len;
  logic [15:0] count_inc;

  assign hdr_len   = {len_hi_q, byte_i};
  assign count_inc = count_q + 16'd1;

  // Next state and result for one byte
  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    frame_len_d = frame_len_q;
    count_d     = count_q;
    result_o    = '{valid: 1'b0, data: 8'd0, last: 1'b0, status: ST_OK};
    if (step_i) begin
      case (phase_q)
        PH_LEN_HI: begin
          len_hi_d = byte_i;
          phase_d  = PH_LEN_LO;
          count_d  = 16'd1;
        end
        PH_LEN_LO: begin
          if (hdr_len <= HdrLen16) begin
            result_o.valid  = 1'b1;
            result_o.status = ST_TOO_SHORT;
            phase_d         = PH_LEN_HI;
            frame_len_d     = 16'd0;
            count_d         = 16'd0;
          end else if ((hdr_len - HdrLen16) > max_payload_i) begin
            result_o.valid  = 1'b1;
            result_o.status = ST_TOO_LONG;
            phase_d         = PH_LEN_HI;
            frame_len_d     = 16'd0;
            count_d         = 16'd0;
          end else begin
            frame_len_d = hdr_len;
            phase_d     = PH_PAYLOAD;
            count_d     = HdrLen16;
          end
        end
        default: begin
          // payload pass-through, last byte closes the frame
          result_o.valid = 1'b1;
          result_o.data  = byte_i;
          if (count_inc >= frame_len_q) begin
            result_o.last = 1'b1;
            phase_d       = PH_LEN_HI;
            frame_len_d   = 16'd0;
            count_d       = 16'd0;
          end else begin
            count_d = count_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN_HI;
      len_hi_q    <= 8'd0;
      frame_len_q <= 16'd0;
      count_q     <= 16'd0;
    end else begin
      phase_q     <= phase_d;
      len_hi_q    <= len_hi_d;
      frame_len_q <= frame_len_d;
      count_q     <= count_d;
    end
  end

endmodule

`default_nettype wire

[rtl/length_prefix_deframer_unit.sv]
// ----------------------------------------------------------------------------
// Length-prefix deframer
// Strips a 16-bit big-endian length header from a byte stream and forwards
// the payload bytes, marking the last byte of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the raw stream, one byte per word. Each frame begins with
//   a two-byte big-endian length that includes the header. Header bytes give
//   no output word; each payload byte leaves on m_axis with tuser = ok, and
//   the final one has tlast set. A length of 2 or less gives one word with
//   tuser = too short, a payload above the limit one word with tuser = too
//   long (tdata 0, tlast 0 in both); the block then waits for a new header.
//   cfg carries the payload limit (reset 16384); write it only while idle.
//   The limit is checked when the header completes.
//   A byte passes the input register, then the output register.
//   Throughput: one byte per cycle while m_axis_tready is not held low;
//   the input register advances whenever the output register is empty or
//   being drained, so a stalled receiver holds one word in the output
//   register, one byte in the input register, then deasserts s_axis_tready.
//   Reset clears both registers and returns to waiting for a header.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_deframer_unit import lpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,     // max_payload_bytes
  // byte stream in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i, // [7:0] data_byte
  // payload out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o, // [7:0] payload_byte
  output logic             m_axis_tlast_o, // end_of_frame
  output logic [1:0]       m_axis_tuser_o  // [1:0] frame_status
);

  logic [15:0]   max_payload_q;
  logic          in_valid_q, in_valid_d;
  logic [7:0]    in_byte_q;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q;
  logic          out_last_q;
  frame_status_e out_status_q;
  logic          advance;
  lpd_result_t   result;

  // Limit register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_valid_i) begin
      max_payload_q <= cfg_data_i;
    end
  end

  // Input word moves on when the output register can take a result
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  lpd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .max_payload_i (max_payload_q),
    .result_o      (result)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && result.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_data_q   <= result.data;
      out_last_q   <= result.last;
      out_status_q <= result.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Length-prefix deframer testbench
// Drives a byte stream into the deframer and checks every output word
// against a built-in prediction of the frame tracker. The run opens with
// directed frames (header extremes, short and long lengths, limit edges, a
// limit change in the middle of a frame), then random phases under several
// payload limits. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import lpd_pkg::*;

  localparam int DrainCycles = 6;
  localparam int RandomPhaseBytes = 140;

  // Expected output word
  typedef struct packed {
    logic [7:0]    payload;
    logic          eof;
    frame_status_e status;
  } deframed_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'd0;
  logic        m_ready = 1'b1;
  logic        cfg_ready_o;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [1:0]  m_axis_tuser_o;

  // Stimulus and expectation stores
  logic [7:0]     raw_bytes[$];
  deframed_word_t expected_words[$];
  int             n_pushed = 0;
  int             n_accepted = 0;
  int             n_fail = 0;

  // Predicted deframer state
  phase_e      trk_phase = PH_LEN_HI;
  logic [7:0]  trk_len_hi = 8'd0;
  logic [15:0] trk_frame_len = 16'd0;
  logic [15:0] trk_taken = 16'd0;
  logic [15:0] payload_limit = MaxPayloadReset;

  // Idle control
  int s_gap = 0;
  int s_calm = 0;
  int m_stall = 0;
  int m_calm = 0;

  length_prefix_deframer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),       // max_payload_bytes
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),         // [7:0] data_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o), // [7:0] payload_byte
    .m_axis_tlast_o  (m_axis_tlast_o), // end_of_frame
    .m_axis_tuser_o  (m_axis_tuser_o)  // [1:0] frame_status
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Append one expected word to the end of the queue
  task automatic expect_word(input logic [7:0] payload, input logic eof,
                             input frame_status_e status);
    deframed_word_t w;
    w.payload = payload;
    w.eof     = eof;
    w.status  = status;
    expected_words = {expected_words, w};
  endtask

  // Frame tracker prediction for one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] len;
    case (trk_phase)
      PH_LEN_HI: begin
        trk_len_hi = b;
        trk_phase  = PH_LEN_LO;
        trk_taken  = 16'd1;
      end
      PH_LEN_LO: begin
        len = {trk_len_hi, b};
        if (len <= HeaderLen) begin
          expect_word(8'd0, 1'b0, ST_TOO_SHORT);
          trk_phase = PH_LEN_HI;
          trk_frame_len = 16'd0;
          trk_taken = 16'd0;
        end else if (32'(len) - HeaderLen > 32'(payload_limit)) begin
          expect_word(8'd0, 1'b0, ST_TOO_LONG);
          trk_phase = PH_LEN_HI;
          trk_frame_len = 16'd0;
          trk_taken = 16'd0;
        end else begin
          trk_phase = PH_PAYLOAD;
          trk_frame_len = len;
          trk_taken = 16'(HeaderLen);
        end
      end
      default: begin
        // payload phase (the unused code counts as payload too)
        trk_taken = trk_taken + 16'd1;
        if (trk_taken >= trk_frame_len) begin
          expect_word(b, 1'b1, ST_OK);
          trk_phase = PH_LEN_HI;
          trk_frame_len = 16'd0;
          trk_taken = 16'd0;
        end else begin
          expect_word(b, 1'b0, ST_OK);
        end
      end
    endcase
  endtask

  // Input driver: one byte per word, random gaps between words
  always @(posedge clk_i) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_valid;
    nxt_data  = s_data;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        deframe_byte(s_data);
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (s_gap > 0) begin
          s_gap--;
        end else if (raw_bytes.size() > 0) begin
          nxt_data  = raw_bytes.pop_front();
          nxt_valid = 1'b1;
          if (s_calm > 0) begin
            s_calm--;
            s_gap = 0;
          end else begin
            s_gap = pick_gap();
            if ($urandom_range(0, 63) == 0) s_calm = $urandom_range(20, 80);
          end
        end
      end
    end
    s_valid <= nxt_valid;
    s_data  <= nxt_data;
  end

  task automatic check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      n_fail++;
    end
  endtask

  // Output monitor and receiver stalls
  always @(posedge clk_i) begin
    deframed_word_t want;
    logic           nxt_ready;
    nxt_ready = m_ready;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: tdata %0h tlast %0b tuser %0h",
                 m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
          n_fail++;
        end else begin
          want = expected_words.pop_front();
          check_field("payload_byte", want.payload, m_axis_tdata_o);
          check_field("end_of_frame", want.eof, m_axis_tlast_o);
          check_field("frame_status", want.status, m_axis_tuser_o);
        end
      end
      if (m_stall > 0) begin
        m_stall--;
        nxt_ready = (m_stall == 0);
      end else if (m_calm > 0) begin
        m_calm--;
        nxt_ready = 1'b1;
      end else begin
        m_stall = pick_gap();
        nxt_ready = (m_stall == 0);
        if ($urandom_range(0, 63) == 0) m_calm = $urandom_range(20, 80);
      end
    end
    m_ready <= nxt_ready;
  end

  task automatic add_byte(input logic [7:0] b);
    raw_bytes = {raw_bytes, b};
    n_pushed++;
  endtask

  task automatic add_header(input int len);
    add_byte(8'(len >> 8));
    add_byte(8'(len));
  endtask

  // Wait until every byte is taken and every word has come out
  task automatic wait_idle();
    do begin
      while (n_accepted != n_pushed || expected_words.size() != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end while (n_accepted != n_pushed || expected_words.size() != 0);
  endtask

  // Payload limit write, only while idle
  task automatic write_payload_limit(input logic [15:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    payload_limit = value;
    cfg_valid <= 1'b0;
  endtask

  // One random frame, mostly well formed, shaped by the current limit
  task automatic add_random_frame();
    int r;
    int n;
    int cap;
    r = $urandom_range(0, 99);
    if (r < 70 && payload_limit != 0) begin
      cap = (payload_limit < 12) ? payload_limit : 12;
      n = $urandom_range(1, cap);
      if ($urandom_range(0, 9) == 0) n = (payload_limit < 40) ? payload_limit : 40;
      add_header(n + 2);
      repeat (n) add_byte(8'($urandom));
    end else if (r < 82 && payload_limit < 16'd65533) begin
      n = payload_limit + 1 + $urandom_range(0, 3);
      if (n > 65533) n = 65533;
      add_header(n + 2);
    end else if (r < 90 || payload_limit > 16'd64) begin
      add_header($urandom_range(0, 2));
    end else begin
      // noise or a broken frame: the tracker may lose alignment
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
    end
  endtask

  // Main sequence
  initial begin
    logic [15:0] limits[10];
    int start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limit: shortest frame, too-short lengths, too-long extremes
    add_header(3); add_byte(8'hAA);
    add_header(0);
    add_header(2);
    add_header(16'hFFFF);
    add_header(16384 + 3);
    add_header(5); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h5A);
    wait_idle();

    // Limit of one: exact fit, one over
    write_payload_limit(16'd1);
    add_header(3); add_byte(8'hFF);
    add_header(4);
    wait_idle();

    // Zero limit: every frame with payload is too long
    write_payload_limit(16'd0);
    add_header(3);
    add_header(1);
    wait_idle();

    // Frame accepted under limit 4, limit lowered in the middle of it
    write_payload_limit(16'd4);
    add_header(6); add_byte(8'h11);
    wait_idle();
    write_payload_limit(16'd1);
    add_byte(8'h22); add_byte(8'h33); add_byte(8'h44);
    add_header(6);
    wait_idle();

    // Random phases under several limits
    limits = '{16'd65533, 16'hFFFF, 16'd1, 16'($urandom_range(2, 40)),
               MaxPayloadReset, 16'($urandom_range(41, 64)), 16'd0,
               16'($urandom), 16'($urandom_range(1, 64)), 16'hAAAA};
    foreach (limits[i]) begin
      write_payload_limit(limits[i]);
      start = n_pushed;
      while (n_pushed - start < RandomPhaseBytes) add_random_frame();
      wait_idle();
    end

    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/lpd_pkg.sv
rtl/lpd_core.sv
rtl/length_prefix_deframer_unit.sv
sim/tb_top.sv
